### src/transfer_offer_validator_macros.svh
// Assertion helpers used by tov_back.
`ifndef TRANSFER_OFFER_VALIDATOR_MACROS_SVH
`define TRANSFER_OFFER_VALIDATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tov_pkg.sv
package tov_pkg;

  localparam int unsigned HDR_LEN         = 14;
  localparam int unsigned CHUNK_LEN       = 12;
  localparam int unsigned PATH_MAX_BYTES  = 4096;
  localparam int unsigned NAME_MAX_BYTES  = 256;
  localparam int unsigned KIND_MAX_BYTES  = 1024;
  localparam int unsigned SEG_LIMIT_BOUND = 1024;
  localparam int unsigned CNT_W           = 20;
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam int unsigned OUT_W           = 120;

  localparam logic CFG_MAX_FILE = 1'b0;
  localparam logic CFG_MAX_SEG  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_RANGE = 3'd2,
    ST_LEN   = 3'd3,
    ST_TERM  = 3'd4,
    ST_GAP   = 3'd5,
    ST_SUM   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        term_pos;
    logic        in_chunk;
    status_t     pre;
    logic [15:0] code;
    logic [15:0] path;
    logic [15:0] name;
    logic [15:0] kind;
    logic [31:0] flen;
    logic [15:0] segs;
  } tov_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] code;
    logic [15:0] path;
    logic [15:0] name;
    logic [15:0] kind;
    logic [31:0] flen;
    logic [15:0] segs;
  } tov_verdict_t;

endpackage

### src/tov_front.sv
module tov_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                last,
  input  logic [31:0]         max_file,
  input  logic [10:0]         max_seg,
  output tov_pkg::tov_word_t  word
);

  logic [tov_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_after;
  logic                      ovf_r, ovf_nxt, ovf_after;
  logic [63:0]               hdr0_r, hdr0_nxt;
  logic [47:0]               hdr1_r, hdr1_nxt;
  logic [tov_pkg::CNT_W-1:0] t1_r, t2_r, t3_r, str_end_r, chunk_end_r;
  logic [tov_pkg::CNT_W-1:0] t1_c, t2_c, t3_c, str_end_c, chunk_end_c, implied;
  logic [15:0]               p, n, k, s;
  logic [31:0]               fl;
  logic [10:0]               lim;
  logic                      ok, body;

  always_comb begin
    hdr0_nxt = hdr0_r;
    hdr1_nxt = hdr1_r;
    if (!ovf_r && cnt_r < tov_pkg::CNT_W'(8)) begin
      hdr0_nxt = {hdr0_r[55:0], data_byte};
    end else if (!ovf_r && cnt_r < tov_pkg::CNT_W'(tov_pkg::HDR_LEN)) begin
      hdr1_nxt = {hdr1_r[39:0], data_byte};
    end
    p  = hdr0_nxt[47:32];
    n  = hdr0_nxt[31:16];
    k  = hdr0_nxt[15:0];
    fl = hdr1_nxt[47:16];
    s  = hdr1_nxt[15:0];
    lim = (max_seg > 11'(tov_pkg::SEG_LIMIT_BOUND)) ? 11'(tov_pkg::SEG_LIMIT_BOUND) : max_seg;
    ok = (p != 16'd0) && (p <= 16'(tov_pkg::PATH_MAX_BYTES)) &&
         (n != 16'd0) && (n <= 16'(tov_pkg::NAME_MAX_BYTES)) &&
         (k != 16'd0) && (k <= 16'(tov_pkg::KIND_MAX_BYTES)) &&
         (fl != 32'd0) && (fl <= max_file) &&
         (s != 16'd0) && (s <= {5'd0, lim});

    t1_c        = tov_pkg::CNT_W'(tov_pkg::HDR_LEN - 1) + {4'd0, p};
    t2_c        = t1_c + {4'd0, n};
    t3_c        = t2_c + {4'd0, k};
    str_end_c   = t3_c + tov_pkg::CNT_W'(1);
    chunk_end_c = str_end_r + {1'b0, s, 3'd0} + {2'b0, s, 2'd0};
    implied     = (cnt_r == tov_pkg::CNT_W'(tov_pkg::HDR_LEN - 1)) ? chunk_end_c : chunk_end_r;

    ovf_after = ovf_r || (cnt_r == tov_pkg::CNT_MAX);
    cnt_after = (cnt_r == tov_pkg::CNT_MAX) ? cnt_r : cnt_r + tov_pkg::CNT_W'(1);
    body = !ovf_r && (cnt_r >= tov_pkg::CNT_W'(tov_pkg::HDR_LEN)) && ok;

    word.data     = data_byte;
    word.last     = last;
    word.term_pos = body && ((cnt_r == t1_r) || (cnt_r == t2_r) || (cnt_r == t3_r));
    word.in_chunk = body && (cnt_r >= str_end_r) && (cnt_r < chunk_end_r);
    if (!ovf_after && cnt_after < tov_pkg::CNT_W'(tov_pkg::HDR_LEN)) begin
      word.pre = tov_pkg::ST_SHORT;
    end else if (!ok) begin
      word.pre = tov_pkg::ST_RANGE;
    end else if (ovf_after || cnt_after != implied) begin
      word.pre = tov_pkg::ST_LEN;
    end else begin
      word.pre = tov_pkg::ST_OK;
    end
    word.code = hdr0_nxt[63:48];
    word.path = p;
    word.name = n;
    word.kind = k;
    word.flen = fl;
    word.segs = s;

    cnt_nxt = last ? '0 : cnt_after;
    ovf_nxt = last ? 1'b0 : ovf_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      hdr0_r <= '0;
      hdr1_r <= '0;
    end else if (acc) begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      hdr0_r <= last ? '0 : hdr0_nxt;
      hdr1_r <= last ? '0 : hdr1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && cnt_r == tov_pkg::CNT_W'(7)) begin
      t1_r      <= t1_c;
      t2_r      <= t2_c;
      t3_r      <= t3_c;
      str_end_r <= str_end_c;
    end
    if (acc && cnt_r == tov_pkg::CNT_W'(tov_pkg::HDR_LEN - 1)) begin
      chunk_end_r <= chunk_end_c;
    end
  end

endmodule

### src/tov_fifo.sv
module tov_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tov_pkg::tov_word_t wdata,
  input  logic               pop,
  output tov_pkg::tov_word_t rdata,
  output logic               not_empty,
  output logic               full
);

  tov_pkg::tov_word_t mem_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;

  assign rdata     = mem_r[rp_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

### src/tov_back.sv
`include "transfer_offer_validator_macros.svh"

module tov_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  tov_pkg::tov_word_t    w,
  output logic                  pop,
  input  logic                  out_ready,
  output logic                  out_valid,
  output tov_pkg::tov_verdict_t verdict
);

  logic [3:0]            cbi_r, cbi_nxt;
  logic [63:0]           off_r, off_nxt, run_r, run_nxt;
  logic [31:0]           size_r, size_nxt;
  logic                  term_r, term_nxt, gap_r, gap_nxt;
  logic                  out_valid_r;
  tov_pkg::tov_verdict_t verdict_r, verdict_nxt;

  assign pop       = q_valid && (!w.last || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign verdict   = verdict_r;

  always_comb begin
    cbi_nxt  = cbi_r;
    off_nxt  = off_r;
    size_nxt = size_r;
    run_nxt  = run_r;
    term_nxt = term_r || (w.term_pos && w.data != 8'd0);
    gap_nxt  = gap_r;
    if (w.in_chunk) begin
      if (cbi_r < 4'd8) begin
        off_nxt = {off_r[55:0], w.data};
      end else begin
        size_nxt = {size_r[23:0], w.data};
      end
      if (cbi_r == 4'(tov_pkg::CHUNK_LEN - 1)) begin
        gap_nxt  = gap_r || (off_r != run_r);
        run_nxt  = run_r + {32'd0, size_nxt};
        off_nxt  = '0;
        size_nxt = '0;
        cbi_nxt  = 4'd0;
      end else begin
        cbi_nxt = cbi_r + 4'd1;
      end
    end

    verdict_nxt.code = w.code;
    verdict_nxt.path = w.path;
    verdict_nxt.name = w.name;
    verdict_nxt.kind = w.kind;
    verdict_nxt.flen = w.flen;
    verdict_nxt.segs = w.segs;
    if (w.pre != tov_pkg::ST_OK) begin
      verdict_nxt.status = w.pre;
    end else if (term_nxt) begin
      verdict_nxt.status = tov_pkg::ST_TERM;
    end else if (gap_nxt) begin
      verdict_nxt.status = tov_pkg::ST_GAP;
    end else if (run_nxt != {32'd0, w.flen}) begin
      verdict_nxt.status = tov_pkg::ST_SUM;
    end else begin
      verdict_nxt.status = tov_pkg::ST_OK;
    end
    if (w.pre == tov_pkg::ST_SHORT) begin
      verdict_nxt.code = '0;
      verdict_nxt.path = '0;
      verdict_nxt.name = '0;
      verdict_nxt.kind = '0;
      verdict_nxt.flen = '0;
      verdict_nxt.segs = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbi_r       <= '0;
      off_r       <= '0;
      size_r      <= '0;
      run_r       <= '0;
      term_r      <= 1'b0;
      gap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && w.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        if (w.last) begin
          cbi_r  <= '0;
          off_r  <= '0;
          size_r <= '0;
          run_r  <= '0;
          term_r <= 1'b0;
          gap_r  <= 1'b0;
        end else begin
          cbi_r  <= cbi_nxt;
          off_r  <= off_nxt;
          size_r <= size_nxt;
          run_r  <= run_nxt;
          term_r <= term_nxt;
          gap_r  <= gap_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && w.last) verdict_r <= verdict_nxt;
  end

  `TOV_ASSERT_SAME(a_cbi_bound, 1'b1, cbi_r < 4'(tov_pkg::CHUNK_LEN), "chunk index out of range")
  `TOV_ASSERT_NEXT(a_last_clears, pop && w.last, cbi_r == 4'd0 && !term_r && !gap_r, "state kept")
  `TOV_ASSERT_SAME(a_short_zero, out_valid_r && verdict_r.status == tov_pkg::ST_SHORT,
                   verdict_r.flen == 32'd0 && verdict_r.code == 16'd0, "short verdict fields")

endmodule

### src/transfer_offer_validator.sv
// Validates a transfer offer message taken one byte word per cycle while the
// queue is not full: the 14-byte header, its field ranges, the string
// terminators, the chunk tiling and the total length, and emits one verdict
// word with the decoded header (zeroed for a short message) on the byte marked
// last. The front counter and header capture feed a two-word queue, and the
// back part does the 64-bit offset add for each chunk. The verdict word is
// registered when the back part pops the last byte's word from the queue.
module transfer_offer_validator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // data_byte
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[2:0], offer_code, path_bytes, name_bytes, kind_bytes,
  // total_file_bytes, segment_count, zero fill
  output logic [tov_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [31:0]               cfg_wdata
);

  logic [31:0]           max_file_r;
  logic [10:0]           max_seg_r;
  logic                  acc, q_valid, q_full, pop;
  tov_pkg::tov_word_t    fw, qw;
  tov_pkg::tov_verdict_t verdict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_file_r <= '1;
      max_seg_r  <= 11'd64;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tov_pkg::CFG_MAX_FILE: max_file_r <= cfg_wdata;
        tov_pkg::CFG_MAX_SEG:  max_seg_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  tov_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_tdata),
    .last      (in_tlast),
    .max_file  (max_file_r),
    .max_seg   (max_seg_r),
    .word      (fw)
  );

  tov_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .wdata     (fw),
    .pop       (pop),
    .rdata     (qw),
    .not_empty (q_valid),
    .full      (q_full)
  );

  tov_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .w         (qw),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .verdict   (verdict)
  );

  assign out_tdata = {5'd0, verdict.segs, verdict.flen, verdict.kind, verdict.name,
                      verdict.path, verdict.code, verdict.status};

endmodule

### bench/tov_checker.sv
module tov_checker
  import tov_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           verdicts_pending,
  output int           verdicts_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  bit [31:0]   max_file;
  bit [10:0]   max_seg;
  bit [63:0]   hdr_hi;
  bit [47:0]   hdr_lo;
  bit [63:0]   entry_offset;
  bit [31:0]   entry_size;
  int unsigned entry_pos;
  bit [63:0]   next_offset;
  bit          term_missing;
  bit          gap_seen;
  int unsigned byte_total;
  bit          saturated;
  tov_verdict_t verdict_q[$];

  function automatic bit header_ok();
    int unsigned lim;
    lim = (max_seg > SEG_LIMIT_BOUND) ? SEG_LIMIT_BOUND : max_seg;
    if (hdr_hi[47:32] == 0 || hdr_hi[47:32] > PATH_MAX_BYTES) return 0;
    if (hdr_hi[31:16] == 0 || hdr_hi[31:16] > NAME_MAX_BYTES) return 0;
    if (hdr_hi[15:0] == 0 || hdr_hi[15:0] > KIND_MAX_BYTES) return 0;
    if (hdr_lo[47:16] == 0 || hdr_lo[47:16] > max_file) return 0;
    if (hdr_lo[15:0] == 0 || hdr_lo[15:0] > lim) return 0;
    return 1;
  endfunction

  function automatic int unsigned strings_end();
    return HDR_LEN + hdr_hi[47:32] + hdr_hi[31:16] + hdr_hi[15:0];
  endfunction

  task automatic clear_message();
    hdr_hi = '0;
    hdr_lo = '0;
    entry_offset = '0;
    entry_size = '0;
    entry_pos = 0;
    next_offset = '0;
    term_missing = 0;
    gap_seen = 0;
    byte_total = 0;
    saturated = 0;
  endtask

  task automatic take_body_byte(input int unsigned idx, input bit [7:0] b);
    int unsigned send;
    int unsigned cend;
    send = strings_end();
    cend = send + CHUNK_LEN * hdr_lo[15:0];
    if (idx == HDR_LEN + hdr_hi[47:32] - 1 ||
        idx == HDR_LEN + hdr_hi[47:32] + hdr_hi[31:16] - 1 || idx == send - 1) begin
      if (b != 0) term_missing = 1;
    end
    if (idx >= send && idx < cend) begin
      if (entry_pos < 8) entry_offset = {entry_offset[55:0], b};
      else entry_size = {entry_size[23:0], b};
      entry_pos++;
      if (entry_pos >= CHUNK_LEN) begin
        if (entry_offset != next_offset) gap_seen = 1;
        next_offset += entry_size;
        entry_offset = '0;
        entry_size = '0;
        entry_pos = 0;
      end
    end
  endtask

  task automatic take_byte(input bit [7:0] b, input bit fin);
    int unsigned idx;
    tov_verdict_t v;
    idx = byte_total;
    if (!saturated) begin
      if (idx < 8) hdr_hi = {hdr_hi[55:0], b};
      else if (idx < HDR_LEN) hdr_lo = {hdr_lo[39:0], b};
      else if (header_ok()) take_body_byte(idx, b);
    end
    if (byte_total >= CNT_MAX) saturated = 1;
    else byte_total++;
    if (!fin) return;
    if (!saturated && byte_total < HDR_LEN) v.status = ST_SHORT;
    else if (!header_ok()) v.status = ST_RANGE;
    else if (saturated || byte_total != strings_end() + CHUNK_LEN * hdr_lo[15:0])
      v.status = ST_LEN;
    else if (term_missing) v.status = ST_TERM;
    else if (gap_seen) v.status = ST_GAP;
    else if (next_offset != {32'd0, hdr_lo[47:16]}) v.status = ST_SUM;
    else v.status = ST_OK;
    if (v.status == ST_SHORT) begin
      {v.code, v.path, v.name, v.kind, v.flen, v.segs} = '0;
    end else begin
      v.code = hdr_hi[63:48];
      v.path = hdr_hi[47:32];
      v.name = hdr_hi[31:16];
      v.kind = hdr_hi[15:0];
      v.flen = hdr_lo[47:16];
      v.segs = hdr_lo[15:0];
    end
    verdict_q.push_back(v);
    clear_message();
  endtask

  task automatic report(input string what, input longint unsigned exp_v,
                        input longint unsigned got_v);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v,
             got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tov_verdict_t e;
    if (!rst_n) begin
      max_file = 32'hFFFF_FFFF;
      max_seg = 11'd64;
      clear_message();
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_MAX_FILE) max_file = cfg_wdata;
        else max_seg = cfg_wdata[10:0];
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          report("unexpected verdict word", 0, out_tdata[2:0]);
        end else begin
          e = verdict_q.pop_front();
          if (out_tdata[2:0] != e.status) report("status", e.status, out_tdata[2:0]);
          if (out_tdata[18:3] != e.code) report("offer_code", e.code, out_tdata[18:3]);
          if (out_tdata[34:19] != e.path) report("path_bytes", e.path, out_tdata[34:19]);
          if (out_tdata[50:35] != e.name) report("name_bytes", e.name, out_tdata[50:35]);
          if (out_tdata[66:51] != e.kind) report("kind_bytes", e.kind, out_tdata[66:51]);
          if (out_tdata[98:67] != e.flen)
            report("total_file_bytes", e.flen, out_tdata[98:67]);
          if (out_tdata[114:99] != e.segs)
            report("segment_count", e.segs, out_tdata[114:99]);
          if (out_tdata[119:115] != 0) report("zero fill", 0, out_tdata[119:115]);
        end
      end
    end
    verdicts_pending = verdict_q.size();
  end

  initial begin
    fail_count = 0;
    verdicts_pending = 0;
    verdicts_seen = 0;
  end
endmodule

### bench/tb_transfer_offer_validator.sv
module tb_transfer_offer_validator;
  import tov_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLAW_NONE  = 0;
  localparam int FLAW_SHORT = 1;
  localparam int FLAW_RANGE = 2;
  localparam int FLAW_LEN   = 3;
  localparam int FLAW_TERM  = 4;
  localparam int FLAW_GAP   = 5;
  localparam int FLAW_SUM   = 6;
  localparam int FLAW_NOISE = 7;
  localparam int FLAW_CUT   = 8;
  localparam longint CYCLE_LIMIT = 200000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [119:0] out_tdata;
  logic         cfg_we = 0;
  logic         cfg_addr = CFG_MAX_FILE;
  logic [31:0]  cfg_wdata = '0;
  int           fail_count;
  int           verdicts_pending;
  int           verdicts_seen;
  longint       cycles = 0;
  bit           steady = 0;
  int           messages_sent = 0;
  bit [7:0]     offer_bytes[$];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  transfer_offer_validator u_top (.*);

  tov_checker u_checker (.*);

  always @(posedge clk) begin
    int r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_transfer_offer_validator NOT OK");
      $finish;
    end
    r = $urandom_range(0, 99);
    if (steady) out_tready <= 1;
    else if (r < 3) out_tready <= 0;
    else if (r < 70) out_tready <= 1;
    else if (r < 85) out_tready <= 0;
    else out_tready <= out_tready;
  end

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_word(input bit [7:0] b, input bit fin);
    int g;
    bit taken;
    g = idle_gap();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    in_tlast <= fin;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_message();
    foreach (offer_bytes[i]) send_word(offer_bytes[i], i == offer_bytes.size() - 1);
    messages_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input bit [31:0] val);
    drain();
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic put_be(input bit [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) offer_bytes.push_back(v[8*i +: 8]);
  endtask

  function automatic int body_start(input int p, input int n, input int k);
    return HDR_LEN + p + n + k;
  endfunction

  task automatic build_offer(input bit [15:0] code, input bit [15:0] p, input bit [15:0] n,
                             input bit [15:0] k, input bit [31:0] flen,
                             input bit [15:0] segs, input int flaw);
    bit [63:0] off;
    bit [31:0] left;
    bit [31:0] sz;
    int cut;
    int last_size_pos;
    offer_bytes = {};
    put_be(code, 2);
    put_be(p, 2);
    put_be(n, 2);
    put_be(k, 2);
    put_be(flen, 4);
    put_be(segs, 2);
    if (flaw == FLAW_SHORT) begin
      offer_bytes = offer_bytes[0:$urandom_range(0, 12)];
      return;
    end
    if (flaw == FLAW_RANGE || flaw == FLAW_CUT) begin
      repeat ($urandom_range(0, 6)) offer_bytes.push_back($urandom);
      return;
    end
    for (int s = 0; s < 3; s++) begin
      int len;
      len = (s == 0) ? p : (s == 1) ? n : k;
      for (int i = 0; i < len - 1; i++) offer_bytes.push_back($urandom);
      offer_bytes.push_back(8'h00);
    end
    if (flaw == FLAW_TERM) begin
      cut = $urandom_range(0, 2);
      cut = HDR_LEN + p - 1 + ((cut > 0) ? n : 0) + ((cut > 1) ? k : 0);
      offer_bytes[cut] = $urandom_range(1, 255);
    end
    off = 0;
    left = flen;
    last_size_pos = 0;
    for (int i = 0; i < segs; i++) begin
      sz = (i == segs - 1) ? left : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, left));
      left -= sz;
      put_be(off, 8);
      last_size_pos = offer_bytes.size();
      put_be(sz, 4);
      off += sz;
    end
    if (flaw == FLAW_GAP) begin
      cut = body_start(p, n, k) + CHUNK_LEN * $urandom_range(0, segs - 1) + $urandom_range(0, 7);
      offer_bytes[cut] = offer_bytes[cut] ^ (8'h1 << $urandom_range(0, 7));
    end
    if (flaw == FLAW_SUM)
      offer_bytes[last_size_pos + 3] = offer_bytes[last_size_pos + 3] ^ 8'h01;
    if (flaw == FLAW_LEN) begin
      if ($urandom_range(0, 1)) offer_bytes.push_back($urandom);
      else void'(offer_bytes.pop_back());
    end
  endtask

  task automatic random_offer();
    int r;
    int flaw;
    bit [15:0] p, n, k, segs;
    bit [31:0] flen;
    r = $urandom_range(0, 99);
    flaw = (r < 45) ? FLAW_NONE : (r < 95) ? $urandom_range(FLAW_SHORT, FLAW_NOISE) : FLAW_NONE;
    p = $urandom_range(1, 3);
    n = $urandom_range(1, 3);
    k = $urandom_range(1, 3);
    segs = $urandom_range(1, 2);
    flen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'hFFFF_FFFF) : $urandom_range(1, 5000);
    if (flaw == FLAW_RANGE) begin
      case ($urandom_range(0, 4))
        0: p = ($urandom_range(0, 1)) ? 0 : $urandom_range(4097, 65535);
        1: n = ($urandom_range(0, 1)) ? 0 : $urandom_range(257, 65535);
        2: k = ($urandom_range(0, 1)) ? 0 : $urandom_range(1025, 65535);
        3: flen = 0;
        default: segs = ($urandom_range(0, 1)) ? 0 : $urandom_range(1025, 65535);
      endcase
    end
    if (flaw == FLAW_NOISE) begin
      offer_bytes = {};
      repeat ($urandom_range(1, 60)) offer_bytes.push_back($urandom);
    end else begin
      build_offer($urandom, p, n, k, flen, segs, flaw);
    end
    send_message();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    build_offer(16'h0000, 1, 1, 1, 1, 1, FLAW_NONE); send_message();
    build_offer(16'hFFFF, 4096, 256, 1024, 32'hFFFF_FFFF, 64, FLAW_CUT); send_message();
    build_offer(16'h1234, 4097, 1, 1, 10, 1, FLAW_RANGE); send_message();
    build_offer(16'h1234, 1, 257, 1, 10, 1, FLAW_RANGE); send_message();
    build_offer(16'h1234, 1, 1, 1025, 10, 1, FLAW_RANGE); send_message();
    build_offer(16'h1234, 0, 1, 1, 10, 1, FLAW_RANGE); send_message();
    build_offer(16'h1234, 1, 1, 1, 10, 65, FLAW_RANGE); send_message();
    build_offer(16'h1234, 1, 1, 1, 10, 0, FLAW_RANGE); send_message();
    build_offer(16'h1234, 1, 1, 1, 0, 1, FLAW_RANGE); send_message();
    build_offer(16'hA5A5, 1, 2, 1, 100, 2, FLAW_SHORT); send_message();
    build_offer(16'hA5A5, 1, 2, 1, 100, 2, FLAW_LEN); send_message();
    build_offer(16'hA5A5, 1, 2, 1, 100, 2, FLAW_TERM); send_message();
    build_offer(16'hA5A5, 1, 2, 1, 100, 2, FLAW_GAP); send_message();
    build_offer(16'hA5A5, 1, 2, 1, 100, 2, FLAW_SUM); send_message();
    build_offer(16'h5A5A, 1, 1, 1, 32'hFFFF_FFFF, 2, FLAW_NONE);
    for (int i = 0; i < 4; i++) offer_bytes[offer_bytes.size() - 4 + i] = 8'hFF;
    send_message();

    write_reg(CFG_MAX_SEG, 1024);
    build_offer(16'h0F0F, 3, 3, 3, 5000, 1024, FLAW_CUT); send_message();
    build_offer(16'h0F0F, 3, 3, 3, 5000, 1025, FLAW_RANGE); send_message();
    write_reg(CFG_MAX_FILE, 1);
    write_reg(CFG_MAX_SEG, 1);
    build_offer(16'h7777, 2, 2, 2, 1, 1, FLAW_NONE); send_message();
    build_offer(16'h7777, 2, 2, 2, 2, 1, FLAW_RANGE); send_message();
    build_offer(16'h7777, 2, 2, 2, 1, 2, FLAW_RANGE); send_message();

    write_reg(CFG_MAX_FILE, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_SEG, 64);
    for (int i = 0; i < 8; i++) begin
      if (i == 3) write_reg(CFG_MAX_FILE, $urandom_range(1000, 5000));
      if (i == 3) write_reg(CFG_MAX_SEG, $urandom_range(1, 2));
      if (i == 6) write_reg(CFG_MAX_FILE, 32'hFFFF_FFFF);
      if (i == 6) write_reg(CFG_MAX_SEG, 64);
      if (i % 3 == 0) steady = !steady;
      random_offer();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d offer messages: boundary headers, every kind of flaw and random ones",
             messages_sent);
    $display("under several limit settings; %0d verdict words checked.", verdicts_seen);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("tb_transfer_offer_validator OK");
    end else begin
      $display("tb_transfer_offer_validator NOT OK");
    end
    $finish;
  end
endmodule
